// File: rtl/seq_pkg.sv
// ----------------------------------------------------------------------------
// seq_pkg
// shared types and constants for the sorted event queue
// ----------------------------------------------------------------------------
package seq_pkg;

    localparam int DEPTH_DEF    = 16;
    localparam int KEY_BITS_DEF = 8;
    localparam int KIND_W       = 3;
    localparam int KEY_W        = 8;
    localparam int HANDLE_W     = 32;
    localparam int ENTRIES_W    = 5;

    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DELETE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
    } t_req;

    typedef struct packed {
        logic                 ok;
        logic [ENTRIES_W-1:0] entries;
        logic                 empty_res;
        logic [KEY_W-1:0]     front_key;
        logic [HANDLE_W-1:0]  front_handle;
    } t_res;

    typedef struct packed {
        logic ins;
        logic push;
        logic pop;
        logic del;
        logic clr;
    } t_cell_cmd;

endpackage

// File: rtl/sorted_event_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_event_queue_top
// result: the strobe o_done is registered and rises in the cycle after a request is taken
// throughput: one request per cycle, busy stays low; every cell updates in
// the same cycle, the find chain through the cells sets the cycle time
// reset: synchronous, active low; the queue is empty after reset, the
// receiver cannot stall and takes every result in its strobe cycle
// ----------------------------------------------------------------------------
module sorted_event_queue_top
    import seq_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_done,
    output t_res o_res
);

    localparam int CW = $clog2(DEPTH + 1);

    logic                w_valid  [DEPTH];
    logic [KEY_BITS-1:0] w_key    [DEPTH];
    logic [HANDLE_W-1:0] w_handle [DEPTH];
    logic                w_found  [DEPTH];
    logic                w_hit    [DEPTH];
    logic [DEPTH-1:0]    w_valids;

    logic                w_accept;
    logic                w_full;
    logic                w_hit_all;
    logic [KEY_BITS-1:0] w_new_key;
    t_cell_cmd           w_cmd;

    logic                r_done;
    logic                r_ok;
    logic [CW-1:0]       r_count;
    logic                n_ok;
    logic [CW-1:0]       n_count;

    assign busy      = 1'b0;
    assign w_accept  = start && !busy;
    assign w_full    = w_valid[DEPTH-1];
    assign w_hit_all = w_hit[DEPTH-1];
    assign w_new_key = KEY_BITS'(i_req.key);

    always_comb begin
        w_cmd      = '0;
        w_cmd.ins  = w_accept && (i_req.kind == KIND_INSERT) && !w_full;
        w_cmd.push = w_accept && (i_req.kind == KIND_PUSH) && !w_full;
        w_cmd.pop  = w_accept && (i_req.kind == KIND_POP) && w_valid[0];
        w_cmd.del  = w_accept && (i_req.kind == KIND_DELETE);
        w_cmd.clr  = w_accept && (i_req.kind == KIND_CLEAR);
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic                w_pv;
            logic [KEY_BITS-1:0] w_pk;
            logic [HANDLE_W-1:0] w_ph;
            logic                w_nv;
            logic [KEY_BITS-1:0] w_nk;
            logic [HANDLE_W-1:0] w_nh;
            logic                w_fi;
            logic                w_hi;

            if (gi == 0) begin : g_head
                assign w_pv = 1'b1;
                assign w_pk = w_new_key;
                assign w_ph = i_req.handle;
                assign w_fi = 1'b0;
                assign w_hi = 1'b0;
            end else begin : g_body
                assign w_pv = w_valid[gi-1];
                assign w_pk = w_key[gi-1];
                assign w_ph = w_handle[gi-1];
                assign w_fi = w_found[gi-1];
                assign w_hi = w_hit[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_tail
                assign w_nv = 1'b0;
                assign w_nk = '0;
                assign w_nh = '0;
            end else begin : g_mid
                assign w_nv = w_valid[gi+1];
                assign w_nk = w_key[gi+1];
                assign w_nh = w_handle[gi+1];
            end

            seq_cell #(
                .KEY_BITS(KEY_BITS)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_cmd         (w_cmd),
                .i_key         (w_new_key),
                .i_handle      (i_req.handle),
                .i_prev_valid  (w_pv),
                .i_prev_key    (w_pk),
                .i_prev_handle (w_ph),
                .i_next_valid  (w_nv),
                .i_next_key    (w_nk),
                .i_next_handle (w_nh),
                .i_found       (w_fi),
                .i_hit         (w_hi),
                .i_hit_all     (w_hit_all),
                .o_valid       (w_valid[gi]),
                .o_key         (w_key[gi]),
                .o_handle      (w_handle[gi]),
                .o_found       (w_found[gi]),
                .o_hit         (w_hit[gi])
            );

            assign w_valids[gi] = w_valid[gi];
        end
    endgenerate

    always_comb begin
        n_ok    = 1'b0;
        n_count = r_count;
        unique case (i_req.kind)
            KIND_INSERT, KIND_PUSH: begin
                n_ok = !w_full;
                if (!w_full) begin
                    n_count = r_count + CW'(1);
                end
            end
            KIND_POP: begin
                n_ok = w_valid[0];
                if (w_valid[0]) begin
                    n_count = r_count - CW'(1);
                end
            end
            KIND_DELETE: begin
                n_ok = w_hit_all;
                if (w_hit_all) begin
                    n_count = r_count - CW'(1);
                end
            end
            KIND_CLEAR: begin
                n_ok    = 1'b1;
                n_count = '0;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= 1'b0;
            r_ok    <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= w_accept;
            if (w_accept) begin
                r_ok    <= n_ok;
                r_count <= n_count;
            end
        end
    end

    assign o_done             = r_done;
    assign o_res.ok           = r_ok;
    assign o_res.entries      = ENTRIES_W'(r_count);
    assign o_res.empty_res    = !w_valid[0];
    assign o_res.front_key    = w_valid[0] ? KEY_W'(w_key[0]) : '0;
    assign o_res.front_handle = w_valid[0] ? w_handle[0] : '0;

    a_count_matches_cells : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CW'($countones(w_valids)))
        else $error("entry count differs from occupied cells");

    a_cells_packed_at_front : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valids & (w_valids + DEPTH'(1))) == '0)
        else $error("occupied cells are not contiguous from the front");

    a_result_follows_request : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_done)
        else $error("accepted request produced no result strobe");

    a_full_refuses_insert : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_full && (i_req.kind == KIND_INSERT || i_req.kind == KIND_PUSH))
        |=> (!r_ok && $stable(r_count)))
        else $error("insert into a full queue was not refused");

endmodule

// File: rtl/seq_cell.sv
// ----------------------------------------------------------------------------
// seq_cell
// one slot of the queue: holds a key and handle, compares against the
// request key and shifts with its neighbors
// ----------------------------------------------------------------------------
module seq_cell
    import seq_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cell_cmd           i_cmd,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic [HANDLE_W-1:0] i_handle,
    input  logic                i_prev_valid,
    input  logic [KEY_BITS-1:0] i_prev_key,
    input  logic [HANDLE_W-1:0] i_prev_handle,
    input  logic                i_next_valid,
    input  logic [KEY_BITS-1:0] i_next_key,
    input  logic [HANDLE_W-1:0] i_next_handle,
    input  logic                i_found,
    input  logic                i_hit,
    input  logic                i_hit_all,
    output logic                o_valid,
    output logic [KEY_BITS-1:0] o_key,
    output logic [HANDLE_W-1:0] o_handle,
    output logic                o_found,
    output logic                o_hit
);

    logic                r_valid;
    logic [KEY_BITS-1:0] r_key;
    logic [HANDLE_W-1:0] r_handle;
    logic                n_valid;
    logic [KEY_BITS-1:0] n_key;
    logic [HANDLE_W-1:0] n_handle;
    logic                w_stop;
    logic                w_match;

    always_comb begin
        if (i_cmd.ins) begin
            w_stop = !r_valid || (r_key > i_key);
        end else begin
            w_stop = !r_valid || (r_key >= i_key);
        end
    end

    assign w_match = !i_found && r_valid && (r_key == i_key);
    assign o_found = i_found || w_stop;
    assign o_hit   = i_hit || w_match;

    always_comb begin
        n_valid  = r_valid;
        n_key    = r_key;
        n_handle = r_handle;
        priority if (i_cmd.clr) begin
            n_valid = 1'b0;
        end else if (i_cmd.push || (i_cmd.ins && i_found)) begin
            n_valid  = i_prev_valid;
            n_key    = i_prev_key;
            n_handle = i_prev_handle;
        end else if (i_cmd.ins && w_stop) begin
            n_valid  = 1'b1;
            n_key    = i_key;
            n_handle = i_handle;
        end else if (i_cmd.pop || (i_cmd.del && i_hit_all && (i_found || w_match))) begin
            n_valid  = i_next_valid;
            n_key    = i_next_key;
            n_handle = i_next_handle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_handle <= n_handle;
    end

    assign o_valid  = r_valid;
    assign o_key    = r_key;
    assign o_handle = r_handle;

endmodule

// File: tb/sorted_event_queue_top_test.sv
// ----------------------------------------------------------------------------
// sorted_event_queue_top_test
// Drives sorted insert, push, pop, delete and clear requests into the queue
// with random gaps and predicts each result from a software copy of the
// queue. Directed tests cover the empty and full queue, key ordering, the
// delete scan that misses after a push, and unused kinds. A random part then
// runs bursts of fill, drain, mixed, narrow-key and push-heavy traffic.
// ----------------------------------------------------------------------------
module sorted_event_queue_top_test;
    import seq_pkg::*;

    localparam int DEPTH    = DEPTH_DEF;
    localparam int KEY_BITS = KEY_BITS_DEF;
    localparam logic [KEY_W-1:0] KEY_MASK = KEY_W'((1 << KEY_BITS) - 1);
    localparam logic [KIND_W-1:0] KIND_RSVD_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_RSVD_LAST  = 3'd7;
    localparam int MAX_GAP        = 13;
    localparam int STALL_LIMIT    = 500;
    localparam int RANDOM_ITEMS   = 1820;

    localparam int REGIME_FILL   = 0;
    localparam int REGIME_DRAIN  = 1;
    localparam int REGIME_MIXED  = 2;
    localparam int REGIME_NARROW = 3;
    localparam int REGIME_PUSHY  = 4;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    logic o_done;
    t_res o_res;

    logic [KEY_W-1:0]    queue_keys [DEPTH];
    logic [HANDLE_W-1:0] queue_handles [DEPTH];
    int                  queue_len;
    t_res                pending_results [$];
    int                  mismatch_count;
    int                  stall_cycles;
    bit                  idle_off;

    sorted_event_queue_top #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_req make_req(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                                      logic [HANDLE_W-1:0] handle);
        t_req r;
        r.kind   = kind;
        r.key    = key;
        r.handle = handle;
        return r;
    endfunction

    // software copy of the queue, updated once per accepted request
    task automatic predict_queue_op(input t_req r, output t_res res);
        logic [KEY_W-1:0] key;
        logic             ok;
        int               pos;
        int               i;
        key = r.key & KEY_MASK;
        ok  = 1'b0;
        case (r.kind)
            KIND_INSERT: begin
                if (queue_len < DEPTH) begin
                    pos = 0;
                    while (pos < queue_len && key >= queue_keys[pos]) pos++;
                    for (i = queue_len; i > pos; i--) begin
                        queue_keys[i]    = queue_keys[i-1];
                        queue_handles[i] = queue_handles[i-1];
                    end
                    queue_keys[pos]    = key;
                    queue_handles[pos] = r.handle;
                    queue_len++;
                    ok = 1'b1;
                end
            end
            KIND_PUSH: begin
                if (queue_len < DEPTH) begin
                    for (i = queue_len; i > 0; i--) begin
                        queue_keys[i]    = queue_keys[i-1];
                        queue_handles[i] = queue_handles[i-1];
                    end
                    queue_keys[0]    = key;
                    queue_handles[0] = r.handle;
                    queue_len++;
                    ok = 1'b1;
                end
            end
            KIND_POP: begin
                if (queue_len > 0) begin
                    for (i = 0; i + 1 < queue_len; i++) begin
                        queue_keys[i]    = queue_keys[i+1];
                        queue_handles[i] = queue_handles[i+1];
                    end
                    queue_len--;
                    ok = 1'b1;
                end
            end
            KIND_DELETE: begin
                pos = 0;
                while (pos < queue_len && queue_keys[pos] < key) pos++;
                if (pos < queue_len && queue_keys[pos] == key) begin
                    for (i = pos; i + 1 < queue_len; i++) begin
                        queue_keys[i]    = queue_keys[i+1];
                        queue_handles[i] = queue_handles[i+1];
                    end
                    queue_len--;
                    ok = 1'b1;
                end
            end
            KIND_CLEAR: begin
                queue_len = 0;
                ok = 1'b1;
            end
            default: begin
            end
        endcase
        res.ok           = ok;
        res.entries      = ENTRIES_W'(queue_len);
        res.empty_res    = (queue_len == 0);
        res.front_key    = (queue_len > 0) ? queue_keys[0] : '0;
        res.front_handle = (queue_len > 0) ? queue_handles[0] : '0;
    endtask

    // one request: optional gap, then hold start until the queue takes it
    task automatic send_request(input t_req r);
        int   gap;
        t_res res;
        gap = idle_off ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= r;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        predict_queue_op(r, res);
        pending_results.push_back(res);
    endtask

    task automatic check_field(input string name, input logic [HANDLE_W-1:0] want,
                               input logic [HANDLE_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (o_done === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result expected none actual %0h", $time, o_res);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("ok", HANDLE_W'(want.ok), HANDLE_W'(o_res.ok));
                check_field("entries", HANDLE_W'(want.entries), HANDLE_W'(o_res.entries));
                check_field("empty_res", HANDLE_W'(want.empty_res),
                            HANDLE_W'(o_res.empty_res));
                check_field("front_key", HANDLE_W'(want.front_key),
                            HANDLE_W'(o_res.front_key));
                check_field("front_handle", want.front_handle, o_res.front_handle);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done === 1'b1) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic test_empty_queue();
        send_request(make_req(KIND_POP, 8'h00, 32'h0));
        send_request(make_req(KIND_DELETE, 8'h00, 32'h0));
        send_request(make_req(KIND_CLEAR, 8'hFF, 32'hFFFF_FFFF));
    endtask

    task automatic test_key_ordering();
        send_request(make_req(KIND_INSERT, 8'h80, 32'h1111_0000));
        send_request(make_req(KIND_INSERT, 8'h80, 32'h2222_0000));
        send_request(make_req(KIND_INSERT, 8'h00, 32'h0000_0000));
        send_request(make_req(KIND_INSERT, 8'hFF, 32'hFFFF_FFFF));
        // push breaks the order, so the scan for 0x80 stops at the front
        send_request(make_req(KIND_PUSH, 8'hC0, 32'hA5A5_5A5A));
        send_request(make_req(KIND_DELETE, 8'h80, 32'h0));
        send_request(make_req(KIND_DELETE, 8'hFF, 32'h0));
        send_request(make_req(KIND_POP, 8'h00, 32'h0));
    endtask

    task automatic test_full_queue();
        while (queue_len < DEPTH)
            send_request(make_req(KIND_INSERT, 8'($urandom_range(0, 255)), $urandom()));
        send_request(make_req(KIND_INSERT, 8'h00, 32'h1234_5678));
        send_request(make_req(KIND_PUSH, 8'hFF, 32'h8765_4321));
    endtask

    task automatic test_unused_kinds();
        int k;
        for (k = int'(KIND_RSVD_FIRST); k <= int'(KIND_RSVD_LAST); k++) begin
            send_request(make_req(KIND_W'(k), 8'($urandom_range(0, 255)), $urandom()));
        end
    endtask

    task automatic test_clear();
        send_request(make_req(KIND_CLEAR, 8'h5A, 32'h0));
    endtask

    task automatic test_random_traffic(input int n_items);
        int                  sent;
        int                  burst_left;
        int                  regime;
        int                  roll;
        logic [KIND_W-1:0]   kind;
        logic [KEY_W-1:0]    key;
        sent       = 0;
        burst_left = 0;
        regime     = REGIME_MIXED;
        while (sent < n_items) begin
            if (burst_left == 0) begin
                regime     = $urandom_range(REGIME_FILL, REGIME_PUSHY);
                burst_left = $urandom_range(10, 60);
                idle_off   = ($urandom_range(0, 3) == 0);
            end
            burst_left--;
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
                kind = KIND_CLEAR;
            end else if (roll < 4) begin
                kind = KIND_W'($urandom_range(KIND_RSVD_FIRST, KIND_RSVD_LAST));
            end else begin
                roll = $urandom_range(0, 99);
                case (regime)
                    REGIME_FILL:  kind = roll < 75 ? KIND_INSERT : roll < 85 ? KIND_PUSH :
                                         roll < 90 ? KIND_POP : KIND_DELETE;
                    REGIME_DRAIN: kind = roll < 15 ? KIND_INSERT : roll < 20 ? KIND_PUSH :
                                         roll < 60 ? KIND_POP : KIND_DELETE;
                    REGIME_PUSHY: kind = roll < 30 ? KIND_INSERT : roll < 70 ? KIND_PUSH :
                                         roll < 80 ? KIND_POP : KIND_DELETE;
                    default:      kind = roll < 35 ? KIND_INSERT : roll < 45 ? KIND_PUSH :
                                         roll < 70 ? KIND_POP : KIND_DELETE;
                endcase
            end
            if (regime == REGIME_NARROW)
                key = 8'($urandom_range(0, 3)) | ($urandom_range(0, 1) ? 8'hFC : 8'h00);
            else
                key = 8'($urandom_range(0, 255));
            // deletes mostly aim at a key that is queued
            if (kind == KIND_DELETE && queue_len > 0 && $urandom_range(0, 9) < 6)
                key = queue_keys[$urandom_range(0, queue_len - 1)];
            send_request(make_req(kind, key, $urandom()));
            if (kind < KIND_RSVD_FIRST) sent++;
        end
        idle_off = 1'b0;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_req          = '0;
        queue_len      = 0;
        mismatch_count = 0;
        stall_cycles   = 0;
        idle_off       = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_queue();
        test_key_ordering();
        test_full_queue();
        test_unused_kinds();
        test_clear();
        test_random_traffic(RANDOM_ITEMS);

        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: sorted_event_queue_top.f
rtl/seq_pkg.sv
rtl/seq_cell.sv
rtl/sorted_event_queue_top.sv
tb/sorted_event_queue_top_test.sv
